/* src/positional_list_store_unit_defines.svh */
// Assertion macros shared by the checker of the positional list store.
// No dependencies; include guarded.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pls check failed");

// Next-cycle implication, disabled while reset is asserted
`define PLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pls check failed");

`endif

/* src/pls_pkg.sv */
// Package for the positional list store: op and status codes, cell control.
// No dependencies.
package pls_pkg;

  localparam int DataW = 32;
  localparam int PosW  = 7;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_MODIFY = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    ins;   // shift up from pos0, write val at pos0
    logic                    del;   // shift down into pos0 and above
    logic                    wr;    // overwrite at pos0
    logic                    rd;    // drive entry at pos0 onto the read bus
    logic [PosW-1:0]         pos0;  // zero-based position
    logic signed [DataW-1:0] val;
  } cell_ctl_t;

endpackage

/* src/pls_cell.sv */
// One storage cell of the list: holds one entry, shifts from its neighbors.
// Depends on pls_pkg.
module pls_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk_i,
  input  pls_pkg::cell_ctl_t             ctl_i,
  input  logic signed [pls_pkg::DataW-1:0] left_i,
  input  logic signed [pls_pkg::DataW-1:0] right_i,
  output logic signed [pls_pkg::DataW-1:0] data_o,
  output logic signed [pls_pkg::DataW-1:0] rd_o
);

  localparam bit InRange = (IDX < (1 << pls_pkg::PosW));
  localparam logic [pls_pkg::PosW-1:0] Idx7 = pls_pkg::PosW'(IDX);

  logic signed [pls_pkg::DataW-1:0] data_q, data_d;
  logic at_pos, above;

  // Where this cell sits relative to the addressed position
  assign at_pos = InRange && (ctl_i.pos0 == Idx7);
  assign above  = !InRange || (Idx7 > ctl_i.pos0);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (at_pos) begin
        data_d = ctl_i.val;
      end
    end else if (ctl_i.del) begin
      if (above || at_pos) begin
        data_d = right_i;
      end
    end else if (ctl_i.wr && at_pos) begin
      data_d = ctl_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // One-hot read: only the addressed cell drives a nonzero word
  assign rd_o   = (ctl_i.rd && at_pos) ? data_q : '0;

endmodule

/* src/positional_list_store_unit.sv */
// Positional list store: done_o rises in the cycle after accept; one item per
// cycle while not busy. Insert and delete shift the cells from the addressed
// position up together; a read selects the addressed cell onto a one-hot bus.
// Reset clears the length; busy is high for the first cycle after reset.
// Cell contents are undefined until written. The receiver cannot stall.
module positional_list_store_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       op_i,
  input  logic [pls_pkg::PosW-1:0]         position_i,
  input  logic signed [pls_pkg::DataW-1:0] item_value_i,
  output logic                             done_o,
  output logic signed [pls_pkg::DataW-1:0] read_value_o,
  output logic [1:0]                       status_o,
  output logic [pls_pkg::PosW-1:0]         length_now_o,
  output logic                             is_empty_o
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > pls_pkg::PosW) ? LW : pls_pkg::PosW) + 1;

  logic                  busy_q, done_q;
  logic [LW-1:0]         len_q, len_d;
  logic [CW-1:0]         pos_x, len_x, len_d_x;
  logic                  accept, full, pos_zero;
  pls_pkg::cell_ctl_t    ctl;
  pls_pkg::status_e      st_d, st_q;
  logic signed [pls_pkg::DataW-1:0] rd_bus, rd_q;
  logic signed [pls_pkg::DataW-1:0] cell_data [CAPACITY];
  logic signed [pls_pkg::DataW-1:0] rd_part   [CAPACITY];

  assign accept   = start && !busy_q;
  assign pos_x    = CW'(position_i);
  assign len_x    = CW'(len_q);
  assign full     = (len_q == LW'(CAPACITY));
  assign pos_zero = (position_i == '0);

  // Request decode: status, new length and cell control
  always_comb begin
    len_d    = len_q;
    st_d     = pls_pkg::ST_OK;
    ctl      = '0;
    ctl.pos0 = position_i - pls_pkg::PosW'(1);
    ctl.val  = item_value_i;
    if (accept) begin
      case (op_i)
        pls_pkg::OP_CLEAR: begin
          len_d = '0;
        end
        pls_pkg::OP_INSERT: begin
          if (full) begin
            st_d = pls_pkg::ST_FULL;
          end else if (pos_zero || (pos_x > len_x + CW'(1))) begin
            st_d = pls_pkg::ST_BADPOS;
          end else begin
            ctl.ins = 1'b1;
            len_d   = len_q + LW'(1);
          end
        end
        pls_pkg::OP_DELETE, pls_pkg::OP_MODIFY, pls_pkg::OP_READ: begin
          if (len_q == '0) begin
            st_d = pls_pkg::ST_EMPTY;
          end else if (pos_zero || (pos_x > len_x)) begin
            st_d = pls_pkg::ST_BADPOS;
          end else if (op_i == pls_pkg::OP_DELETE) begin
            ctl.del = 1'b1;
            len_d   = len_q - LW'(1);
          end else if (op_i == pls_pkg::OP_MODIFY) begin
            ctl.wr = 1'b1;
          end else begin
            ctl.rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells; each neighbor pair is wired for shifting
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [pls_pkg::DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[k];
    end else begin : g_right
      assign right_w = cell_data[k+1];
    end
    pls_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .rd_o    (rd_part[k])
    );
  end

  // OR the one-hot read contributions
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_part[k];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      len_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      done_q <= accept;
      len_q  <= len_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= rd_bus;
      st_q <= st_d;
    end
  end

  assign len_d_x      = CW'(len_q);
  assign busy         = busy_q;
  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign status_o     = st_q;
  assign length_now_o = len_d_x[pls_pkg::PosW-1:0];
  assign is_empty_o   = (len_q == '0);

endmodule

/* src/pls_checker.sv */
// Port-level checker for positional_list_store_unit, bound to the top level.
// Depends on pls_pkg and positional_list_store_unit_defines.svh.
`include "positional_list_store_unit_defines.svh"

module pls_checker #(
  parameter int CAPACITY = 64
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic signed [pls_pkg::DataW-1:0] read_value_o,
  input logic [1:0]                       status_o,
  input logic [pls_pkg::PosW-1:0]         length_now_o,
  input logic                             is_empty_o
);

  localparam logic [pls_pkg::PosW-1:0] CapMasked = pls_pkg::PosW'(CAPACITY);

  // Every accepted item gets its result in the next cycle
  `PLS_ASSERT_NXT(a_done_after_accept, clk_i, rst_ni, start && !busy, done_o)
  // No result without an accepted item
  `PLS_ASSERT_NXT(a_no_stray_done, clk_i, rst_ni, !(start && !busy), !done_o)
  // A failed request never returns data
  `PLS_ASSERT_IMP(a_err_zero_data, clk_i, rst_ni,
                  done_o && (status_o != pls_pkg::ST_OK), read_value_o == '0)
  // Full is reported only at capacity
  `PLS_ASSERT_IMP(a_full_len, clk_i, rst_ni,
                  done_o && (status_o == pls_pkg::ST_FULL), length_now_o == CapMasked)
  // An empty list reports a zero length
  `PLS_ASSERT_IMP(a_empty_len, clk_i, rst_ni, done_o && is_empty_o, length_now_o == '0)

endmodule

bind positional_list_store_unit pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .length_now_o (length_now_o),
  .is_empty_o   (is_empty_o)
);
